FILE: sv/ftoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftoa_pkg
// Shared constants and types for the float to decimal ascii converter.
// ----------------------------------------------------------------------------
package ftoa_pkg;

    localparam int FRAC_DIGITS_DEF = 6;
    localparam int INT_DIGITS_DEF  = 10;

    localparam int STORE_DEPTH = 10;
    localparam int ND_W        = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int INT_BITS    = 31;
    localparam int FRAC_BITS   = 32;
    localparam int DD_W        = $clog2(INT_BITS + 1);
    localparam int COUNT_W     = 5;
    localparam int MAX_CHARS   = 19;

    localparam logic [7:0] EXPO_LIMIT = 8'd158;
    localparam logic [FRAC_BITS-1:0] FRAC_THRESHOLD = 32'd4295;

    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_DOT     = 8'h2e;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
    localparam logic [7:0] CHAR_NONE    = 8'h00;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_CONV    = 10'b00_0000_0010,
        S_CHECK   = 10'b00_0000_0100,
        S_SIGN    = 10'b00_0000_1000,
        S_INT     = 10'b00_0001_0000,
        S_DOT     = 10'b00_0010_0000,
        S_FRAC    = 10'b00_0100_0000,
        S_NEWLINE = 10'b00_1000_0000,
        S_ZERO    = 10'b01_0000_0000,
        S_FAIL    = 10'b10_0000_0000
    } state_t;

endpackage

FILE: sv/float_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_decimal_ascii
// Converts one IEEE-754 single into decimal ascii text, one character per
// result: optional sign, integer digits, point, truncated fraction digits,
// and a newline that is marked last and carries the character count.
//
// Usage:
//   float_valid/float_stall/float_bits carry one request; it is taken when
//   float_valid is high and float_stall is low. float_stall stays high from
//   acceptance until the newline (or error) result has been loaded into the
//   output register, so one request is worked on at a time.
//   char_valid/char_stall carry the results; the output register holds a
//   result for as long as char_stall is high, and the block simply waits.
//   A zero input goes straight to output: "0" then newline.
//   Otherwise the integer part goes through a bit-serial double dabble over
//   its 31 bits, while the fraction makes one digit per cycle (times ten) in
//   the same window, then a check state. Characters follow at one per cycle
//   while char_stall is low; a request gives n characters, at most 19.
//   NaN, infinity and magnitudes of 2^31 and up give one error result
//   without conversion; the check state also gives it if the digits do not
//   fit. The error result is loaded once the output register is free.
//   Reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module float_to_decimal_ascii #(
    parameter int FRAC_DIGITS = ftoa_pkg::FRAC_DIGITS_DEF,
    parameter int INT_DIGITS  = ftoa_pkg::INT_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        float_valid,
    output logic        float_stall,
    input  logic [31:0] float_bits,
    output logic        char_valid,
    input  logic        char_stall,
    output logic [7:0]  character,
    output logic        last,
    output logic        error,
    output logic [4:0]  char_count
);

    localparam int JW = $clog2(FRAC_DIGITS + 1);

    ftoa_pkg::state_t state_reg, state_next;

    logic [ftoa_pkg::DD_W-1:0]      dd_cnt_reg, dd_cnt_next;
    logic [ftoa_pkg::INT_BITS-1:0]  ip_reg, ip_next;
    logic [ftoa_pkg::FRAC_BITS-1:0] fp_reg, fp_next;
    logic [3:0]                     bcd_reg [ftoa_pkg::STORE_DEPTH];
    logic [3:0]                     bcd_next [ftoa_pkg::STORE_DEPTH];
    logic [3:0]                     frac_reg [FRAC_DIGITS];
    logic [3:0]                     frac_next [FRAC_DIGITS];
    logic [JW-1:0]                  jf_reg, jf_next;
    logic [ftoa_pkg::ND_W-1:0]      int_cnt_reg, int_cnt_next;
    logic                           neg_reg, neg_next;
    logic [ftoa_pkg::COUNT_W-1:0]   cnt_reg, cnt_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_last_reg, out_last_next;
    logic       out_err_reg, out_err_next;
    logic [4:0] out_count_reg, out_count_next;

    logic        out_free;
    logic [7:0]  expo;
    logic [23:0] mant;
    logic signed [9:0] sh;
    logic signed [9:0] sh_neg;
    logic [63:0] v;
    logic [3:0]  bcd_adj [ftoa_pkg::STORE_DEPTH];
    logic [35:0] prod;
    logic        frac_go;
    logic [ftoa_pkg::ND_W-1:0] nd;
    logic [ftoa_pkg::COUNT_W-1:0] len_sum;
    logic [3:0]  int_digit;

    assign float_stall = (state_reg != ftoa_pkg::S_IDLE);
    assign char_valid  = out_valid_reg;
    assign character   = out_char_reg;
    assign last        = out_last_reg;
    assign error       = out_err_reg;
    assign char_count  = out_count_reg;

    assign out_free = !out_valid_reg || !char_stall;

    // alignment of the mantissa into q31.32
    always_comb
    begin
        expo   = float_bits[30:23];
        mant   = {(expo != 8'd0), float_bits[22:0]};
        sh     = (expo == 8'd0) ? -10'sd117 : ($signed({2'b00, expo}) - 10'sd118);
        sh_neg = -sh;
        if (!sh[9])
        begin
            v = {40'd0, mant} << sh[5:0];
        end
        else
        begin
            v = {40'd0, mant} >> sh_neg[6:0];
        end
    end

    // double dabble step and leading digit search
    always_comb
    begin
        nd = '0;
        for (int i = 0; i < ftoa_pkg::STORE_DEPTH; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
            if (bcd_reg[i] != 4'd0)
            begin
                nd = ftoa_pkg::ND_W'(i + 1);
            end
        end
    end

    assign prod    = ({4'd0, fp_reg} << 3) + ({4'd0, fp_reg} << 1);
    assign frac_go = (jf_reg < JW'(FRAC_DIGITS)) && (fp_reg >= ftoa_pkg::FRAC_THRESHOLD);
    assign len_sum = ftoa_pkg::COUNT_W'(neg_reg) + ftoa_pkg::COUNT_W'(nd)
                   + ftoa_pkg::COUNT_W'(jf_reg);
    assign int_digit = bcd_reg[ftoa_pkg::IDX_W'(int_cnt_reg - 1'b1)];

    always_comb
    begin
        state_next     = state_reg;
        dd_cnt_next    = dd_cnt_reg;
        ip_next        = ip_reg;
        fp_next        = fp_reg;
        bcd_next       = bcd_reg;
        frac_next      = frac_reg;
        jf_next        = jf_reg;
        int_cnt_next   = int_cnt_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && char_stall;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        out_count_next = out_count_reg;

        case (state_reg)
            ftoa_pkg::S_IDLE:
            begin
                if (float_valid)
                begin
                    neg_next    = float_bits[31];
                    cnt_next    = '0;
                    jf_next     = '0;
                    dd_cnt_next = ftoa_pkg::DD_W'(ftoa_pkg::INT_BITS);
                    ip_next     = v[62:32];
                    fp_next     = v[31:0];
                    for (int i = 0; i < ftoa_pkg::STORE_DEPTH; i++)
                    begin
                        bcd_next[i] = 4'd0;
                    end
                    if (float_bits[30:0] == 31'd0)
                    begin
                        state_next = ftoa_pkg::S_ZERO;
                    end
                    else if (expo >= ftoa_pkg::EXPO_LIMIT)
                    begin
                        state_next = ftoa_pkg::S_FAIL;
                    end
                    else
                    begin
                        state_next = ftoa_pkg::S_CONV;
                    end
                end
            end
            ftoa_pkg::S_CONV:
            begin
                for (int i = 0; i < ftoa_pkg::STORE_DEPTH; i++)
                begin
                    if (i == 0)
                    begin
                        bcd_next[i] = {bcd_adj[i][2:0], ip_reg[ftoa_pkg::INT_BITS-1]};
                    end
                    else
                    begin
                        bcd_next[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
                    end
                end
                ip_next     = {ip_reg[ftoa_pkg::INT_BITS-2:0], 1'b0};
                dd_cnt_next = dd_cnt_reg - 1'b1;
                if (frac_go)
                begin
                    for (int i = 0; i < FRAC_DIGITS; i++)
                    begin
                        if (jf_reg == JW'(i))
                        begin
                            frac_next[i] = prod[35:32];
                        end
                    end
                    fp_next = prod[31:0];
                    jf_next = jf_reg + 1'b1;
                end
                if (dd_cnt_reg == ftoa_pkg::DD_W'(1))
                begin
                    state_next = ftoa_pkg::S_CHECK;
                end
            end
            ftoa_pkg::S_CHECK:
            begin
                int_cnt_next = nd;
                if ((nd > ftoa_pkg::ND_W'(INT_DIGITS))
                    || (len_sum >= ftoa_pkg::COUNT_W'(ftoa_pkg::MAX_CHARS - 1)))
                begin
                    state_next = ftoa_pkg::S_FAIL;
                end
                else if (neg_reg)
                begin
                    state_next = ftoa_pkg::S_SIGN;
                end
                else if (nd != '0)
                begin
                    state_next = ftoa_pkg::S_INT;
                end
                else
                begin
                    state_next = ftoa_pkg::S_DOT;
                end
            end
            ftoa_pkg::S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ftoa_pkg::CHAR_MINUS;
                    out_last_next  = 1'b0;
                    out_err_next   = 1'b0;
                    out_count_next = '0;
                    cnt_next       = cnt_reg + 1'b1;
                    state_next     = (int_cnt_reg != '0) ? ftoa_pkg::S_INT : ftoa_pkg::S_DOT;
                end
            end
            ftoa_pkg::S_INT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ftoa_pkg::CHAR_ZERO + {4'd0, int_digit};
                    out_last_next  = 1'b0;
                    out_err_next   = 1'b0;
                    out_count_next = '0;
                    cnt_next       = cnt_reg + 1'b1;
                    int_cnt_next   = int_cnt_reg - 1'b1;
                    if (int_cnt_reg == ftoa_pkg::ND_W'(1))
                    begin
                        state_next = ftoa_pkg::S_DOT;
                    end
                end
            end
            ftoa_pkg::S_DOT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ftoa_pkg::CHAR_DOT;
                    out_last_next  = 1'b0;
                    out_err_next   = 1'b0;
                    out_count_next = '0;
                    cnt_next       = cnt_reg + 1'b1;
                    state_next     = (jf_reg != '0) ? ftoa_pkg::S_FRAC : ftoa_pkg::S_NEWLINE;
                end
            end
            ftoa_pkg::S_FRAC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ftoa_pkg::CHAR_ZERO + {4'd0, frac_reg[0]};
                    out_last_next  = 1'b0;
                    out_err_next   = 1'b0;
                    out_count_next = '0;
                    cnt_next       = cnt_reg + 1'b1;
                    for (int i = 0; i < FRAC_DIGITS - 1; i++)
                    begin
                        frac_next[i] = frac_reg[i+1];
                    end
                    jf_next = jf_reg - 1'b1;
                    if (jf_reg == JW'(1))
                    begin
                        state_next = ftoa_pkg::S_NEWLINE;
                    end
                end
            end
            ftoa_pkg::S_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ftoa_pkg::CHAR_ZERO;
                    out_last_next  = 1'b0;
                    out_err_next   = 1'b0;
                    out_count_next = '0;
                    cnt_next       = cnt_reg + 1'b1;
                    state_next     = ftoa_pkg::S_NEWLINE;
                end
            end
            ftoa_pkg::S_NEWLINE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ftoa_pkg::CHAR_NEWLINE;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b0;
                    out_count_next = cnt_reg + 1'b1;
                    state_next     = ftoa_pkg::S_IDLE;
                end
            end
            ftoa_pkg::S_FAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = ftoa_pkg::CHAR_NONE;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b1;
                    out_count_next = '0;
                    state_next     = ftoa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next     = ftoa_pkg::S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ftoa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and payload
    always_ff @(posedge clk)
    begin
        dd_cnt_reg    <= dd_cnt_next;
        ip_reg        <= ip_next;
        fp_reg        <= fp_next;
        bcd_reg       <= bcd_next;
        frac_reg      <= frac_next;
        jf_reg        <= jf_next;
        int_cnt_reg   <= int_cnt_next;
        neg_reg       <= neg_next;
        cnt_reg       <= cnt_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
        out_count_reg <= out_count_next;
    end

endmodule

FILE: sim/tb_float_to_decimal_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_float_to_decimal_ascii
// Self-checking bench for the float to decimal ascii converter. A driver
// feeds raw single-precision patterns from a queue and a monitor compares
// every character result with the text that a local formatter predicts for
// each accepted request. Directed corner values come first, then random
// patterns over four idle/stall phases, with a full drain between phases.
// ----------------------------------------------------------------------------
module tb_float_to_decimal_ascii;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 60;

    typedef struct packed {
        logic [7:0]                   character;
        logic                         last;
        logic                         error;
        logic [ftoa_pkg::COUNT_W-1:0] char_count;
    } char_result_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        float_valid = 1'b0;
    logic [31:0] float_bits  = '0;
    logic        char_stall  = 1'b1;
    logic        float_stall;
    logic        char_valid;
    logic [7:0]  character;
    logic        last;
    logic        error;
    logic [4:0]  char_count;

    logic [31:0]  pending_floats [$];
    char_result_t expected_chars [$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int mismatches         = 0;
    int chars_checked      = 0;
    int floats_sent        = 0;
    int idle_cycles        = 0;

    float_to_decimal_ascii u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .float_valid (float_valid),
        .float_stall (float_stall),
        .float_bits  (float_bits),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .character   (character),
        .last        (last),
        .error       (error),
        .char_count  (char_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void predict_text(input logic [31:0] bits);
        logic [7:0]   text [ftoa_pkg::MAX_CHARS];
        logic [3:0]   digits [ftoa_pkg::STORE_DEPTH];
        logic [23:0]  mant;
        logic [63:0]  magnitude;
        logic [31:0]  ip;
        logic [31:0]  fp;
        logic [35:0]  prod;
        char_result_t r;
        int           e;
        int           sh;
        int           n;
        int           nd;
        int           j;
        n = 0;
        if (bits[30:0] == '0)
        begin
            text[n] = ftoa_pkg::CHAR_ZERO;
            n++;
        end
        else if (bits[30:23] >= ftoa_pkg::EXPO_LIMIT)
        begin
            // nan, infinity or out of range
            r = '{ftoa_pkg::CHAR_NONE, 1'b1, 1'b1, '0};
            expected_chars.push_back(r);
            return;
        end
        else
        begin
            if (bits[30:23] == 8'd0)
            begin
                e    = -126;
                mant = {1'b0, bits[22:0]};
            end
            else
            begin
                e    = int'(bits[30:23]) - 127;
                mant = {1'b1, bits[22:0]};
            end
            // q31.32 magnitude
            sh = e + 9;
            if (sh >= 0)
                magnitude = 64'(mant) << sh;
            else if (sh > -64)
                magnitude = 64'(mant) >> (-sh);
            else
                magnitude = '0;
            ip = magnitude[63:32];
            fp = magnitude[31:0];
            nd = 0;
            while (ip != 0)
            begin
                digits[nd] = 4'(ip % 10);
                nd++;
                ip = ip / 10;
            end
            if (bits[31])
            begin
                text[n] = ftoa_pkg::CHAR_MINUS;
                n++;
            end
            for (int k = nd - 1; k >= 0; k--)
            begin
                text[n] = ftoa_pkg::CHAR_ZERO + 8'(digits[k]);
                n++;
            end
            text[n] = ftoa_pkg::CHAR_DOT;
            n++;
            j = 0;
            while (fp >= ftoa_pkg::FRAC_THRESHOLD && j < ftoa_pkg::FRAC_DIGITS_DEF)
            begin
                prod    = 36'(fp) * 36'd10;
                text[n] = ftoa_pkg::CHAR_ZERO + 8'(prod[35:32]);
                n++;
                fp = prod[31:0];
                j++;
            end
        end
        text[n] = ftoa_pkg::CHAR_NEWLINE;
        n++;
        for (int k = 0; k < n; k++)
        begin
            r.character  = text[k];
            r.last       = (k == n - 1);
            r.error      = 1'b0;
            r.char_count = (k == n - 1) ? ftoa_pkg::COUNT_W'(n) : '0;
            expected_chars.push_back(r);
        end
    endfunction

    function automatic logic [31:0] random_float();
        int          pick;
        logic        sign;
        logic [7:0]  expo;
        logic [22:0] mant;
        pick = $urandom_range(99);
        sign = 1'($urandom_range(1));
        mant = 23'($urandom);
        if (pick < 70)
            expo = 8'($urandom_range(157, 110));
        else if (pick < 80)
        begin
            // subnormal, sometimes zero
            expo = 8'd0;
            if (pick < 74)
                mant = '0;
        end
        else if (pick < 90)
            expo = 8'($urandom_range(255, 158));
        else
            return $urandom;
        return {sign, expo, mant};
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            float_valid <= 1'b0;
            float_bits  <= '0;
        end
        else
        begin
            if (float_valid && !float_stall)
            begin
                predict_text(float_bits);
                floats_sent++;
            end
            if (!float_valid || !float_stall)
            begin
                if (pending_floats.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    float_valid <= 1'b1;
                    float_bits  <= pending_floats.pop_front();
                end
                else
                    float_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_stall <= 1'b1;
        else
            char_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        char_result_t want;
        if (rst_n && char_valid && !char_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: char %h last %b err %b count %0d",
                             character, last, error, char_count);
                mismatches++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (character !== want.character || last !== want.last ||
                    error !== want.error || char_count !== want.char_count)
                begin
                    if (mismatches < 10)
                        $display({"mismatch: expected char %h last %b err %b count %0d,",
                                  " got char %h last %b err %b count %0d"},
                                 want.character, want.last, want.error, want.char_count,
                                 character, last, error, char_count);
                    mismatches++;
                end
                chars_checked++;
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((float_valid && !float_stall) || (char_valid && !char_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_random);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n_random)
            pending_floats.push_back(random_float());
        // hold off until every request has fully drained
        while (pending_floats.size() != 0 || float_valid || expected_chars.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int leftover;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // zeros, unit values, subnormals, specials, range edges, fractions
        pending_floats.push_back(32'h0000_0000);
        pending_floats.push_back(32'h8000_0000);
        pending_floats.push_back(32'h3f80_0000);
        pending_floats.push_back(32'hbf80_0000);
        pending_floats.push_back(32'h3f00_0000);
        pending_floats.push_back(32'h0000_0001);
        pending_floats.push_back(32'h807f_ffff);
        pending_floats.push_back(32'h0080_0000);
        pending_floats.push_back(32'h7f80_0000);
        pending_floats.push_back(32'hff80_0000);
        pending_floats.push_back(32'h7fc0_0000);
        pending_floats.push_back(32'h7f80_0001);
        pending_floats.push_back(32'h4f00_0000);
        pending_floats.push_back(32'h4eff_ffff);
        pending_floats.push_back(32'hceff_ffff);
        pending_floats.push_back(32'h7f7f_ffff);
        pending_floats.push_back(32'h3dcc_cccd);
        pending_floats.push_back(32'h4049_0fdb);
        pending_floats.push_back(32'h3586_37bd);
        pending_floats.push_back(32'h3580_0000);
        pending_floats.push_back(32'h3eaa_aaab);
        pending_floats.push_back(32'h461c_4000);
        pending_floats.push_back(32'h3f7f_ffff);
        pending_floats.push_back(32'hc2f6_e979);
        pending_floats.push_back(32'h4b7f_ffff);

        run_phase(0, 0, 36);
        run_phase(62, 0, 36);
        run_phase(0, 62, 36);
        run_phase(15, 15, 37);

        repeat (TAIL_CYCLES) @(posedge clk);
        leftover = expected_chars.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);

        $display("converted %0d float requests into %0d checked characters,", floats_sent,
                 chars_checked);
        $display("under free-running, sender-idle, receiver-stall and mixed phases");
        if (mismatches == 0 && leftover == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
